### rtl/ehb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehb_pkg
// Shared constants, codes and types of the edge hash bucketer.
// ----------------------------------------------------------------------------
package ehb_pkg;

  localparam int unsigned MAX_BUCKETS = 16;
  localparam int unsigned VERTEX_BITS = 16;
  localparam int unsigned COUNT_BITS  = 32;

  // port widths
  localparam int unsigned VID_W      = 16;
  localparam int unsigned QB_W       = 4;
  localparam int unsigned BUCKET_W   = 4;
  localparam int unsigned SLOT_W     = 32;
  localparam int unsigned EDGES_W    = 32;
  localparam int unsigned VCOUNT_W   = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  // configuration
  localparam int unsigned KEY_MODE_W = 2;
  localparam int unsigned NCOUNT_W   = 5;
  localparam logic [CFG_IDX_W-1:0]  CFG_KEY_MODE       = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_BUCKET_COUNT   = 1'd1;
  localparam logic [KEY_MODE_W-1:0] KEY_MODE_INCOMING  = 2'd1;
  localparam logic [KEY_MODE_W-1:0] KEY_MODE_RESET     = 2'd0;
  localparam logic [NCOUNT_W-1:0]   BUCKET_COUNT_RESET = 5'd16;

  // actions
  localparam logic ACT_PLACE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // hash: prime = 2^HASH_PRIME_SHIFT + HASH_PRIME_LO
  localparam int unsigned HASH_XOR         = 3;
  localparam int unsigned HASH_PRIME_SHIFT = 40;
  localparam int unsigned HASH_PRIME_LO    = 435;
  localparam int unsigned DIGIT_BITS       = 8;

  localparam int unsigned SEEN_WORD_LOG_MAX = 6;

  typedef struct packed {
    logic                done;
    logic [NCOUNT_W-1:0] rem;
  } hash_res_t;

  // prime mod n for every bucket count n
  function automatic logic [(1<<NCOUNT_W)*NCOUNT_W-1:0] hash_mult_table();
    logic [(1<<NCOUNT_W)*NCOUNT_W-1:0] tbl;
    int p;
    int q;
    int n;
    int i;
    tbl = '0;
    for (n = 1; n < (1 << NCOUNT_W); n++) begin
      p = (n == 1) ? 0 : 1;
      for (i = 0; i < int'(HASH_PRIME_SHIFT); i++) begin
        p = p * 2;
        if (p >= n) p = p - n;
      end
      q = 0;
      for (i = $clog2(HASH_PRIME_LO + 1) - 1; i >= 0; i--) begin
        q = q * 2 + int'((HASH_PRIME_LO >> i) & 1);
        if (q >= n) q = q - n;
      end
      p = p + q;
      if (p >= n) p = p - n;
      tbl[n*NCOUNT_W +: NCOUNT_W] = NCOUNT_W'(p);
    end
    return tbl;
  endfunction

  localparam logic [(1<<NCOUNT_W)*NCOUNT_W-1:0] HASH_MULT_TBL = hash_mult_table();

endpackage

### rtl/ehb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ehb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ehb_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehb_hash
// Hash of the key vertex reduced modulo the bucket count, one digit a cycle.
// ----------------------------------------------------------------------------
module ehb_hash #(
  parameter int unsigned VertexBits = ehb_pkg::VERTEX_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [VertexBits-1:0]         key_i,
  input  logic [ehb_pkg::NCOUNT_W-1:0]  n_i,
  output ehb_pkg::hash_res_t            res_o
);

  localparam int unsigned MW    = VertexBits + ehb_pkg::NCOUNT_W;
  localparam int unsigned STEPS = (MW + ehb_pkg::DIGIT_BITS - 1) / ehb_pkg::DIGIT_BITS;
  localparam int unsigned PW    = STEPS * ehb_pkg::DIGIT_BITS;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [ehb_pkg::NCOUNT_W-1:0] mult;
  logic [MW-1:0]                prod;
  logic [PW-1:0]                m_q, m_d;
  logic [ehb_pkg::NCOUNT_W-1:0] n_q, n_d;
  logic [ehb_pkg::NCOUNT_W-1:0] r_q, r_d;
  logic [ehb_pkg::NCOUNT_W-1:0] r_step;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic                         done_q, done_d;

  assign mult = ehb_pkg::HASH_MULT_TBL[n_i*ehb_pkg::NCOUNT_W +: ehb_pkg::NCOUNT_W];
  assign prod = MW'(key_i) * MW'(mult);

  always_comb begin
    logic [ehb_pkg::NCOUNT_W:0] t;
    t = {1'b0, r_q};
    for (int i = 0; i < int'(ehb_pkg::DIGIT_BITS); i++) begin
      t = {t[ehb_pkg::NCOUNT_W-1:0], m_q[PW-1-i]};
      if (t >= {1'b0, n_q}) t = t - {1'b0, n_q};
    end
    r_step = t[ehb_pkg::NCOUNT_W-1:0];
  end

  always_comb begin
    m_d    = m_q;
    n_d    = n_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      m_d    = PW'(prod);
      n_d    = n_i;
      r_d    = '0;
      cnt_d  = CW'(STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      m_d   = m_q << ehb_pkg::DIGIT_BITS;
      r_d   = r_step;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    n_q <= n_d;
    r_q <= r_d;
  end

  assign res_o.done = done_q;
  assign res_o.rem  = r_q;

endmodule

### rtl/edge_hash_bucketer_with_stats_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_hash_bucketer_with_stats_top
// Hashes edges into buckets and keeps per-bucket and global vertex statistics.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | action, src/dst vertex, query bucket
//  out     | output    | out_valid_o/out_stall_i | bucket, slot, counts, maxima, minimum
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
//  A placed edge passes the digit-serial modulo unit and then the read-modify-write
//  of the seen bitmap; a query skips the modulo unit.
//  After reset the seen bitmap is cleared, one word a cycle, all
//  MaxBuckets << (VertexBits-6) words (16384 by default); no item is taken then.
//  A finished item waits in the output register while the next item is worked on.
// ----------------------------------------------------------------------------
module edge_hash_bucketer_with_stats_top #(
  parameter int unsigned MaxBuckets = ehb_pkg::MAX_BUCKETS,
  parameter int unsigned VertexBits = ehb_pkg::VERTEX_BITS,
  parameter int unsigned CountBits  = ehb_pkg::COUNT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ehb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ehb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [ehb_pkg::VID_W-1:0]      src_vertex_i,
  input  logic [ehb_pkg::VID_W-1:0]      dst_vertex_i,
  input  logic [ehb_pkg::QB_W-1:0]       query_bucket_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ehb_pkg::BUCKET_W-1:0]   bucket_o,
  output logic [ehb_pkg::SLOT_W-1:0]     slot_o,
  output logic [ehb_pkg::EDGES_W-1:0]    edges_in_bucket_o,
  output logic [ehb_pkg::VCOUNT_W-1:0]   vertices_in_bucket_o,
  output logic [ehb_pkg::VID_W-1:0]      bucket_max_vertex_o,
  output logic [ehb_pkg::VID_W-1:0]      overall_min_vertex_o,
  output logic [ehb_pkg::VID_W-1:0]      overall_max_vertex_o
);

  localparam int unsigned BW    = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int unsigned WL    = (VertexBits < ehb_pkg::SEEN_WORD_LOG_MAX) ?
                                  VertexBits : ehb_pkg::SEEN_WORD_LOG_MAX;
  localparam int unsigned WBITS = 1 << WL;
  localparam int unsigned SHIFT = VertexBits - WL;
  localparam int unsigned SD    = MaxBuckets << SHIFT;
  localparam int unsigned SAW   = (SD > 1) ? $clog2(SD) : 1;
  localparam int unsigned SW    = CountBits + 2 * VertexBits + 1;
  localparam int unsigned VB    = VertexBits;
  localparam int unsigned CB    = CountBits;
  localparam int unsigned NW    = ehb_pkg::NCOUNT_W;
  localparam logic [VB:0] VCNT_MAX = {1'b1, {VB{1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HASH = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_LOOK = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [ehb_pkg::KEY_MODE_W-1:0] key_mode_q;
  logic [NW-1:0]                 bcount_q;
  logic [NW-1:0]                 neff;
  logic                          clr_q, clr_d;
  logic [SAW-1:0]                clr_addr_q, clr_addr_d;
  logic [MaxBuckets-1:0]         stat_vld_q, stat_vld_d;
  logic [VB-1:0]                 gmin_q, gmin_d, gmax_q, gmax_d;

  logic                          act_q, act_d;
  logic [VB-1:0]                 src_q, src_d, dst_q, dst_d;
  logic [ehb_pkg::QB_W-1:0]      qb_q, qb_d;
  logic [BW-1:0]                 b_q, b_d;
  logic                          oob_q, oob_d;
  logic [SW-1:0]                 stat_q, stat_d;
  logic [WBITS-1:0]              src_word_q, src_word_d;
  logic                          src_new_q, src_new_d;

  logic                          out_valid_q, out_valid_d;
  logic [ehb_pkg::BUCKET_W-1:0]  out_bucket_q, out_bucket_d;
  logic [ehb_pkg::SLOT_W-1:0]    out_slot_q, out_slot_d;
  logic [ehb_pkg::EDGES_W-1:0]   out_edges_q, out_edges_d;
  logic [ehb_pkg::VCOUNT_W-1:0]  out_verts_q, out_verts_d;
  logic [ehb_pkg::VID_W-1:0]     out_bmax_q, out_bmax_d;
  logic [ehb_pkg::VID_W-1:0]     out_gmin_q, out_gmin_d;
  logic [ehb_pkg::VID_W-1:0]     out_gmax_q, out_gmax_d;

  logic                          accept;
  logic                          out_free;
  logic                          load;
  logic [VB-1:0]                 in_src, in_dst, key;
  ehb_pkg::hash_res_t            hres;

  logic                          seen_we;
  logic [SAW-1:0]                seen_waddr, seen_raddr;
  logic [WBITS-1:0]              seen_wdata, seen_rdata;
  logic                          seen_re;
  logic [SAW-1:0]                src_addr, dst_addr;
  logic [WBITS-1:0]              src_mask, dst_mask, dst_word;
  logic                          dst_new;

  logic                          stat_we, stat_re;
  logic [SW-1:0]                 stat_wdata, stat_rdata;

  logic [CB-1:0]                 ec, ec_new;
  logic [VB:0]                   vc, vc1, vc2;
  logic [VB-1:0]                 mx, mx1, mx_new;
  logic [VB-1:0]                 gmax1, gmax_new, gmin1, gmin_new;

  assign in_stall_o = (state_q != ST_IDLE) || clr_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = (state_q == ST_DONE) && out_free;

  assign in_src = VB'(src_vertex_i);
  assign in_dst = VB'(dst_vertex_i);
  assign key    = ((key_mode_q == ehb_pkg::KEY_MODE_INCOMING) ? in_dst : in_src)
                  ^ VB'(ehb_pkg::HASH_XOR);

  always_comb begin
    priority if (bcount_q == '0) begin
      neff = NW'(1);
    end else if (32'(bcount_q) > MaxBuckets) begin
      neff = NW'(MaxBuckets);
    end else begin
      neff = bcount_q;
    end
  end

  ehb_hash #(
    .VertexBits(VertexBits)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept && (action_i == ehb_pkg::ACT_PLACE)),
    .key_i  (key),
    .n_i    (neff),
    .res_o  (hres)
  );

  // seen bitmap addressing
  assign src_addr = (SAW'(b_q) << SHIFT) | SAW'(src_q >> WL);
  assign dst_addr = (SAW'(b_q) << SHIFT) | SAW'(dst_q >> WL);
  assign src_mask = WBITS'(1) << src_q[WL-1:0];
  assign dst_mask = WBITS'(1) << dst_q[WL-1:0];
  assign dst_word = (dst_addr == src_addr) ? src_word_q : seen_rdata;
  assign dst_new  = !(|(dst_word & dst_mask));

  always_comb begin
    seen_we    = 1'b0;
    seen_waddr = src_addr;
    seen_wdata = seen_rdata | src_mask;
    if (clr_q) begin
      seen_we    = 1'b1;
      seen_waddr = clr_addr_q;
      seen_wdata = '0;
    end else if ((state_q == ST_LOOK) && (act_q == ehb_pkg::ACT_PLACE)) begin
      seen_we = 1'b1;
    end else if (load && (act_q == ehb_pkg::ACT_PLACE)) begin
      seen_we    = 1'b1;
      seen_waddr = dst_addr;
      seen_wdata = dst_word | dst_mask;
    end
  end

  assign seen_re    = (state_q == ST_READ) || (state_q == ST_LOOK);
  assign seen_raddr = (state_q == ST_READ) ? src_addr : dst_addr;

  ehb_ram #(
    .Width(WBITS),
    .Depth(SD)
  ) u_seen_ram (
    .clk_i  (clk_i),
    .we_i   (seen_we),
    .waddr_i(seen_waddr),
    .wdata_i(seen_wdata),
    .re_i   (seen_re),
    .raddr_i(seen_raddr),
    .rdata_o(seen_rdata)
  );

  // bucket statistics update
  assign ec = stat_q[SW-1:2*VB+1];
  assign vc = stat_q[2*VB:VB];
  assign mx = stat_q[VB-1:0];

  assign ec_new   = (&ec) ? ec : ec + CB'(1);
  assign vc1      = (src_new_q && (vc != VCNT_MAX)) ? vc + (VB+1)'(1) : vc;
  assign vc2      = (dst_new && (vc1 != VCNT_MAX)) ? vc1 + (VB+1)'(1) : vc1;
  assign mx1      = (src_q > mx) ? src_q : mx;
  assign mx_new   = (dst_q > mx1) ? dst_q : mx1;
  assign gmax1    = (src_q > gmax_q) ? src_q : gmax_q;
  assign gmax_new = (dst_q > gmax1) ? dst_q : gmax1;
  assign gmin1    = (src_q < gmin_q) ? src_q : gmin_q;
  assign gmin_new = (dst_q < gmin1) ? dst_q : gmin1;

  assign stat_re    = (state_q == ST_READ);
  assign stat_we    = load && (act_q == ehb_pkg::ACT_PLACE);
  assign stat_wdata = {ec_new, vc2, mx_new};

  ehb_ram #(
    .Width(SW),
    .Depth(MaxBuckets)
  ) u_stat_ram (
    .clk_i  (clk_i),
    .we_i   (stat_we),
    .waddr_i(b_q),
    .wdata_i(stat_wdata),
    .re_i   (stat_re),
    .raddr_i(b_q),
    .rdata_o(stat_rdata)
  );

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    clr_addr_d   = clr_addr_q;
    stat_vld_d   = stat_vld_q;
    gmin_d       = gmin_q;
    gmax_d       = gmax_q;
    act_d        = act_q;
    src_d        = src_q;
    dst_d        = dst_q;
    qb_d         = qb_q;
    b_d          = b_q;
    oob_d        = oob_q;
    stat_d       = stat_q;
    src_word_d   = src_word_q;
    src_new_d    = src_new_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_bucket_d = out_bucket_q;
    out_slot_d   = out_slot_q;
    out_edges_d  = out_edges_q;
    out_verts_d  = out_verts_q;
    out_bmax_d   = out_bmax_q;
    out_gmin_d   = out_gmin_q;
    out_gmax_d   = out_gmax_q;

    if (clr_q) begin
      clr_addr_d = clr_addr_q + SAW'(1);
      if (clr_addr_q == SAW'(SD - 1)) clr_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d = action_i;
          src_d = in_src;
          dst_d = in_dst;
          qb_d  = query_bucket_i;
          b_d   = BW'(query_bucket_i);
          oob_d = (32'(query_bucket_i) >= MaxBuckets);
          state_d = (action_i == ehb_pkg::ACT_PLACE) ? ST_HASH : ST_READ;
        end
      end
      ST_HASH: begin
        if (hres.done) begin
          b_d     = BW'(hres.rem);
          oob_d   = 1'b0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        stat_d     = (stat_vld_q[b_q] && !oob_q) ? stat_rdata : '0;
        src_word_d = seen_rdata | src_mask;
        src_new_d  = !(|(seen_rdata & src_mask));
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (act_q == ehb_pkg::ACT_PLACE) begin
            stat_vld_d[b_q] = 1'b1;
            gmin_d          = gmin_new;
            gmax_d          = gmax_new;
            out_bucket_d    = ehb_pkg::BUCKET_W'(b_q);
            out_slot_d      = ehb_pkg::SLOT_W'(ec);
            out_edges_d     = ehb_pkg::EDGES_W'(ec_new);
            out_verts_d     = ehb_pkg::VCOUNT_W'(vc2);
            out_bmax_d      = ehb_pkg::VID_W'(mx_new);
            out_gmin_d      = ehb_pkg::VID_W'(gmin_new);
            out_gmax_d      = ehb_pkg::VID_W'(gmax_new);
          end else begin
            out_bucket_d = qb_q;
            out_slot_d   = '0;
            out_edges_d  = ehb_pkg::EDGES_W'(ec);
            out_verts_d  = ehb_pkg::VCOUNT_W'(vc);
            out_bmax_d   = ehb_pkg::VID_W'(mx);
            out_gmin_d   = ehb_pkg::VID_W'(gmin_q);
            out_gmax_d   = ehb_pkg::VID_W'(gmax_q);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_mode_q  <= ehb_pkg::KEY_MODE_RESET;
      bcount_q    <= ehb_pkg::BUCKET_COUNT_RESET;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      stat_vld_q  <= '0;
      gmin_q      <= '1;
      gmax_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      stat_vld_q  <= stat_vld_d;
      gmin_q      <= gmin_d;
      gmax_q      <= gmax_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ehb_pkg::CFG_KEY_MODE: begin
            key_mode_q <= cfg_wdata_i[ehb_pkg::KEY_MODE_W-1:0];
          end
          ehb_pkg::CFG_BUCKET_COUNT: begin
            bcount_q <= cfg_wdata_i[NW-1:0];
          end
          default: begin
            bcount_q <= bcount_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    src_q        <= src_d;
    dst_q        <= dst_d;
    qb_q         <= qb_d;
    b_q          <= b_d;
    oob_q        <= oob_d;
    stat_q       <= stat_d;
    src_word_q   <= src_word_d;
    src_new_q    <= src_new_d;
    out_bucket_q <= out_bucket_d;
    out_slot_q   <= out_slot_d;
    out_edges_q  <= out_edges_d;
    out_verts_q  <= out_verts_d;
    out_bmax_q   <= out_bmax_d;
    out_gmin_q   <= out_gmin_d;
    out_gmax_q   <= out_gmax_d;
  end

  assign out_valid_o          = out_valid_q;
  assign bucket_o             = out_bucket_q;
  assign slot_o               = out_slot_q;
  assign edges_in_bucket_o    = out_edges_q;
  assign vertices_in_bucket_o = out_verts_q;
  assign bucket_max_vertex_o  = out_bmax_q;
  assign overall_min_vertex_o = out_gmin_q;
  assign overall_max_vertex_o = out_gmax_q;

endmodule

### rtl/ehb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehb_checker
// Port-level assertions of the edge hash bucketer, bound to the top level.
// ----------------------------------------------------------------------------
module ehb_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [ehb_pkg::BUCKET_W-1:0] bucket_o,
  input logic [ehb_pkg::SLOT_W-1:0]   slot_o,
  input logic [ehb_pkg::EDGES_W-1:0]  edges_in_bucket_o,
  input logic [ehb_pkg::VCOUNT_W-1:0] vertices_in_bucket_o,
  input logic [ehb_pkg::VID_W-1:0]    bucket_max_vertex_o,
  input logic [ehb_pkg::VID_W-1:0]    overall_min_vertex_o,
  input logic [ehb_pkg::VID_W-1:0]    overall_max_vertex_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bucket_o) && $stable(slot_o)
      && $stable(edges_in_bucket_o) && $stable(vertices_in_bucket_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while previous item in work");

  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slot_o <= edges_in_bucket_o)
    else $error("slot beyond bucket edge count");

  a_empty_bucket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (edges_in_bucket_o == '0) |->
      (vertices_in_bucket_o == '0) && (bucket_max_vertex_o == '0))
    else $error("empty bucket shows vertices");

  a_global_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (edges_in_bucket_o != '0) |->
      (overall_min_vertex_o <= overall_max_vertex_o)
      && (bucket_max_vertex_o <= overall_max_vertex_o))
    else $error("global vertex range inconsistent");

endmodule

bind edge_hash_bucketer_with_stats_top ehb_checker u_ehb_checker (.*);
